[src/tpcs_pkg.sv]
`timescale 1ns / 1ps
package tpcs_pkg;

   localparam int CSR_W          = 11;
   localparam int COLOR_W        = 24;
   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 3;
   localparam int INDEX_W        = 20;
   localparam int DEF_MAX_DIM    = 1024;
   localparam int DEF_COORD_BITS = 12;

   // Register indexes on the configuration port.
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] SCREEN_WIDTH_RESET  = CSR_W'(256);
   localparam logic [CSR_W-1:0] SCREEN_HEIGHT_RESET = CSR_W'(240);

endpackage

[src/tpcs_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage for every color channel.
// The quotient is known to fit in CHAN_W bits, so the stages start at the
// shift CHAN_W-1.
module tpcs_divider import tpcs_pkg::*; #(
   parameter int AW = 26,
   parameter int NW = 35
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  logic [AW-1:0]                      area_in,
   input  logic [NUM_CHAN-1:0][NW-1:0]        num_in,
   output logic                               valid_out,
   output logic [NUM_CHAN-1:0][CHAN_W-1:0]    quot_out
);

   logic [CHAN_W-1:0]                         valid_ff;
   logic [CHAN_W-1:0][AW-1:0]                 area_ff;
   logic [CHAN_W-1:0][NUM_CHAN-1:0][NW-1:0]   rem_ff;
   logic [CHAN_W-1:0][NUM_CHAN-1:0][CHAN_W-1:0] quot_ff;

   for (genvar g = 0; g < CHAN_W; g++) begin : g_stage
      logic                              vld_src;
      logic [AW-1:0]                     area_src;
      logic [NUM_CHAN-1:0][NW-1:0]       rem_src;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]   quot_src;
      logic [NW-1:0]                     divisor;
      logic [NUM_CHAN-1:0][NW-1:0]       rem_in;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]   quot_in;

      if (g == 0) begin : g_first
         assign vld_src  = valid_in;
         assign area_src = area_in;
         assign rem_src  = num_in;
         assign quot_src = '0;
      end else begin : g_next
         assign vld_src  = valid_ff[g-1];
         assign area_src = area_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign quot_src = quot_ff[g-1];
      end

      assign divisor = NW'(area_src) << (CHAN_W - 1 - g);

      always_comb begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (rem_src[c] >= divisor) begin
               rem_in[c]  = rem_src[c] - divisor;
               quot_in[c] = {quot_src[c][CHAN_W-2:0], 1'b1};
            end else begin
               rem_in[c]  = rem_src[c];
               quot_in[c] = {quot_src[c][CHAN_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= vld_src;
         end
         area_ff[g] <= area_src;
         rem_ff[g]  <= rem_in;
         quot_ff[g] <= quot_in;
      end
   end

   assign valid_out = valid_ff[CHAN_W-1];
   assign quot_out  = quot_ff[CHAN_W-1];

   a_valid_delay: assert property (@(posedge clock) disable iff (reset)
      valid_in |-> ##CHAN_W valid_out)
      else $error("divider valid bit lost");

   a_valid_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(valid_out))
      else $error("divider valid bit unknown");

   // When the quotient fits, quotient times divisor plus remainder gives back
   // the numerator.
   a_exact_quotient: assert property (@(posedge clock) disable iff (reset)
      valid_in && (num_in[0] < (NW'(area_in) << CHAN_W)) |-> ##CHAN_W
         ((NW'(quot_out[0]) * NW'(area_ff[CHAN_W-1]) + rem_ff[CHAN_W-1][0]) ==
          $past(num_in[0], CHAN_W)))
      else $error("divider quotient inexact");

endmodule

[src/triangle_pixel_color_shader.sv]
`timescale 1ns / 1ps
// Channel   Ports                               Handshake
// request   req_* triangle, colors, pixel       start high, busy low
// response  rsp_* enable, color, index, echo    rsp_valid strobe, one cycle
// config    csr_we, csr_index, csr_data         write on csr_we, no wait
//
// One item enters every cycle; busy is never raised.
// Each item passes through the edge and interpolation arithmetic, eight divider
// stages and one output register.
// Throughput is one item per clock.
// Reset clears the valid bits and sets the screen size to 256 by 240.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module triangle_pixel_color_shader import tpcs_pkg::*; #(
   parameter int MAX_DIM    = DEF_MAX_DIM,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_vert_a_x,
   input  logic signed [COORD_BITS-1:0] req_vert_a_y,
   input  logic signed [COORD_BITS-1:0] req_vert_b_x,
   input  logic signed [COORD_BITS-1:0] req_vert_b_y,
   input  logic signed [COORD_BITS-1:0] req_vert_c_x,
   input  logic signed [COORD_BITS-1:0] req_vert_c_y,
   input  logic [COLOR_W-1:0]           req_color_a,
   input  logic [COLOR_W-1:0]           req_color_b,
   input  logic [COLOR_W-1:0]           req_color_c,
   input  logic signed [COORD_BITS-1:0] req_pixel_x,
   input  logic signed [COORD_BITS-1:0] req_pixel_y,
   output logic                         rsp_valid,
   output logic                         rsp_write_enable,
   output logic [COLOR_W-1:0]           rsp_pixel_color,
   output logic [INDEX_W-1:0]           rsp_buffer_index,
   output logic signed [COORD_BITS-1:0] rsp_echo_x,
   output logic signed [COORD_BITS-1:0] rsp_echo_y,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [CSR_W-1:0]             csr_data
);

   // Coordinate differences, edge products, edge values, channel products.
   localparam int CW   = COORD_BITS;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int EW   = PW + 1;
   localparam int AW   = EW - 1;
   localparam int MPW  = CHAN_W + AW;
   localparam int NW   = EW + CHAN_W;
   localparam int DMW  = $clog2(MAX_DIM + 1);
   localparam int CMPW = (DMW > CSR_W) ? DMW : CSR_W;
   localparam int LAT  = 6 + CHAN_W;

   // Configuration registers.
   logic [CSR_W-1:0] width_ff, height_ff;
   logic [CMPW-1:0]  eff_w, eff_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  width_ff  <= csr_data;
            REG_SCREEN_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Register values above the largest screen dimension are clamped.
   assign eff_w = (CMPW'(width_ff) > CMPW'(MAX_DIM))  ? CMPW'(MAX_DIM) : CMPW'(width_ff);
   assign eff_h = (CMPW'(height_ff) > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : CMPW'(height_ff);

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: coordinate differences and the screen clip.
   logic                  v1_ff;
   logic signed [DW-1:0]  bax_ff, bay_ff, cax_ff, cay_ff, cbx_ff, cby_ff, acx_ff, acy_ff;
   logic signed [DW-1:0]  pbx_ff, pby_ff, pcx_ff, pcy_ff, pax_ff, pay_ff;
   logic [COLOR_W-1:0]    ca1_ff, cb1_ff, cc1_ff;
   logic [CW-1:0]         x1_ff, y1_ff;
   logic                  onscr1_ff;
   logic [CMPW-1:0]       effw1_ff;
   logic                  onscr_in;

   assign onscr_in = !req_pixel_x[CW-1] && !req_pixel_y[CW-1] &&
                     (32'($unsigned(req_pixel_x)) < 32'(eff_w)) &&
                     (32'($unsigned(req_pixel_y)) < 32'(eff_h));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      bax_ff    <= DW'(req_vert_b_x) - DW'(req_vert_a_x);
      bay_ff    <= DW'(req_vert_b_y) - DW'(req_vert_a_y);
      cax_ff    <= DW'(req_vert_c_x) - DW'(req_vert_a_x);
      cay_ff    <= DW'(req_vert_c_y) - DW'(req_vert_a_y);
      cbx_ff    <= DW'(req_vert_c_x) - DW'(req_vert_b_x);
      cby_ff    <= DW'(req_vert_c_y) - DW'(req_vert_b_y);
      acx_ff    <= DW'(req_vert_a_x) - DW'(req_vert_c_x);
      acy_ff    <= DW'(req_vert_a_y) - DW'(req_vert_c_y);
      pbx_ff    <= DW'(req_pixel_x) - DW'(req_vert_b_x);
      pby_ff    <= DW'(req_pixel_y) - DW'(req_vert_b_y);
      pcx_ff    <= DW'(req_pixel_x) - DW'(req_vert_c_x);
      pcy_ff    <= DW'(req_pixel_y) - DW'(req_vert_c_y);
      pax_ff    <= DW'(req_pixel_x) - DW'(req_vert_a_x);
      pay_ff    <= DW'(req_pixel_y) - DW'(req_vert_a_y);
      ca1_ff    <= req_color_a;
      cb1_ff    <= req_color_b;
      cc1_ff    <= req_color_c;
      x1_ff     <= req_pixel_x;
      y1_ff     <= req_pixel_y;
      onscr1_ff <= onscr_in;
      effw1_ff  <= eff_w;
   end

   // Stage 2: the area and edge products and the row offset.
   logic                  v2_ff;
   logic signed [PW-1:0]  pa0_ff, pa1_ff, p0a_ff, p0b_ff, p1a_ff, p1b_ff, p2a_ff, p2b_ff;
   logic [COLOR_W-1:0]    ca2_ff, cb2_ff, cc2_ff;
   logic [CW-1:0]         x2_ff, y2_ff;
   logic                  onscr2_ff;
   logic [INDEX_W-1:0]    row2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      pa0_ff    <= PW'(cay_ff) * PW'(bax_ff);
      pa1_ff    <= PW'(cax_ff) * PW'(bay_ff);
      p0a_ff    <= PW'(pby_ff) * PW'(cbx_ff);
      p0b_ff    <= PW'(pbx_ff) * PW'(cby_ff);
      p1a_ff    <= PW'(pcy_ff) * PW'(acx_ff);
      p1b_ff    <= PW'(pcx_ff) * PW'(acy_ff);
      p2a_ff    <= PW'(pay_ff) * PW'(bax_ff);
      p2b_ff    <= PW'(pax_ff) * PW'(bay_ff);
      row2_ff   <= INDEX_W'(y1_ff) * INDEX_W'(effw1_ff);
      ca2_ff    <= ca1_ff;
      cb2_ff    <= cb1_ff;
      cc2_ff    <= cc1_ff;
      x2_ff     <= x1_ff;
      y2_ff     <= y1_ff;
      onscr2_ff <= onscr1_ff;
   end

   // Stage 3: edge values, area and the inside test.
   logic signed [EW-1:0] area_in, e0_in, e1_in, e2_in;
   logic                 v3_ff, we3_ff;
   logic [AW-1:0]        area3_ff, e0_3_ff, e1_3_ff, e2_3_ff;
   logic [COLOR_W-1:0]   ca3_ff, cb3_ff, cc3_ff;
   logic [CW-1:0]        x3_ff, y3_ff;
   logic [INDEX_W-1:0]   idx3_ff;

   assign area_in = EW'(pa0_ff) - EW'(pa1_ff);
   assign e0_in   = EW'(p0a_ff) - EW'(p0b_ff);
   assign e1_in   = EW'(p1a_ff) - EW'(p1b_ff);
   assign e2_in   = EW'(p2a_ff) - EW'(p2b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      // An edge value of zero counts as inside; a flat or clockwise
      // triangle never draws.
      we3_ff   <= onscr2_ff && (area_in > 0) && !e0_in[EW-1] && !e1_in[EW-1] &&
                  !e2_in[EW-1];
      area3_ff <= area_in[AW-1:0];
      e0_3_ff  <= e0_in[AW-1:0];
      e1_3_ff  <= e1_in[AW-1:0];
      e2_3_ff  <= e2_in[AW-1:0];
      idx3_ff  <= row2_ff + INDEX_W'(x2_ff);
      ca3_ff   <= ca2_ff;
      cb3_ff   <= cb2_ff;
      cc3_ff   <= cc2_ff;
      x3_ff    <= x2_ff;
      y3_ff    <= y2_ff;
   end

   // Stage 4: color channel times edge weight.
   logic                               v4_ff, we4_ff;
   logic [NUM_CHAN-1:0][MPW-1:0]       pra4_ff, prb4_ff, prc4_ff;
   logic [AW-1:0]                      area4_ff;
   logic [CW-1:0]                      x4_ff, y4_ff;
   logic [INDEX_W-1:0]                 idx4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         pra4_ff[c] <= MPW'(ca3_ff[c*CHAN_W +: CHAN_W]) * MPW'(e0_3_ff);
         prb4_ff[c] <= MPW'(cb3_ff[c*CHAN_W +: CHAN_W]) * MPW'(e1_3_ff);
         prc4_ff[c] <= MPW'(cc3_ff[c*CHAN_W +: CHAN_W]) * MPW'(e2_3_ff);
      end
      we4_ff   <= we3_ff;
      area4_ff <= area3_ff;
      idx4_ff  <= idx3_ff;
      x4_ff    <= x3_ff;
      y4_ff    <= y3_ff;
   end

   // Stage 5: weighted sums. The weights add up to the area, so each
   // quotient stays below 256.
   logic                           v5_ff, we5_ff;
   logic [NUM_CHAN-1:0][NW-1:0]    num5_ff;
   logic [AW-1:0]                  area5_ff;
   logic [CW-1:0]                  x5_ff, y5_ff;
   logic [INDEX_W-1:0]             idx5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         num5_ff[c] <= NW'(pra4_ff[c]) + NW'(prb4_ff[c]) + NW'(prc4_ff[c]);
      end
      we5_ff   <= we4_ff;
      area5_ff <= area4_ff;
      idx5_ff  <= idx4_ff;
      x5_ff    <= x4_ff;
      y5_ff    <= y4_ff;
   end

   // Stages 6 to 13: the divider, with the side data delayed alongside.
   logic                              div_valid;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   div_quot;

   tpcs_divider #(
      .AW (AW),
      .NW (NW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v5_ff),
      .area_in   (area5_ff),
      .num_in    (num5_ff),
      .valid_out (div_valid),
      .quot_out  (div_quot)
   );

   logic [CHAN_W-1:0]               side_we_ff;
   logic [CHAN_W-1:0][INDEX_W-1:0]  side_idx_ff;
   logic [CHAN_W-1:0][CW-1:0]       side_x_ff, side_y_ff;

   always_ff @(posedge clock) begin
      side_we_ff[0]  <= we5_ff;
      side_idx_ff[0] <= idx5_ff;
      side_x_ff[0]   <= x5_ff;
      side_y_ff[0]   <= y5_ff;
      for (int i = 1; i < CHAN_W; i++) begin
         side_we_ff[i]  <= side_we_ff[i-1];
         side_idx_ff[i] <= side_idx_ff[i-1];
         side_x_ff[i]   <= side_x_ff[i-1];
         side_y_ff[i]   <= side_y_ff[i-1];
      end
   end

   // Output register: color and index read zero when the pixel is not written.
   logic                 rsp_valid_ff, rsp_we_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [INDEX_W-1:0]   rsp_idx_ff;
   logic [CW-1:0]        rsp_x_ff, rsp_y_ff;
   logic                 out_we;

   assign out_we = side_we_ff[CHAN_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_we_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
         rsp_we_ff    <= div_valid && out_we;
      end
      rsp_color_ff <= out_we ? COLOR_W'(div_quot) : '0;
      rsp_idx_ff   <= out_we ? side_idx_ff[CHAN_W-1] : '0;
      rsp_x_ff     <= side_x_ff[CHAN_W-1];
      rsp_y_ff     <= side_y_ff[CHAN_W-1];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_buffer_index = rsp_idx_ff;
   assign rsp_echo_x       = rsp_x_ff;
   assign rsp_echo_y       = rsp_y_ff;

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("item result missing after fixed latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without a matching item");

   a_enable_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_write_enable |-> rsp_valid)
      else $error("write enable outside a result");

   a_unwritten_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> (rsp_pixel_color == '0) && (rsp_buffer_index == '0))
      else $error("unwritten pixel carries color or index");

endmodule
